/* hw/rtl/epg_pkg.sv */
`default_nettype none

package epg_pkg;

    // Largest echo train that the cell row can hold, one cell per order.
    localparam int MAX_ECHOES = 32;
    localparam int CNT_W      = 6;
    localparam int IDX_W      = 5;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 64;
    localparam int RND_W      = 34;
    localparam int ACC_W      = 36;

    localparam logic signed [DATA_W-1:0] Q_ONE = 32'sh4000_0000;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_ECHO_COUNT = 2'd0,
        CFG_COS_ALPHA  = 2'd1,
        CFG_SIN_ALPHA  = 2'd2,
        CFG_LONG_DECAY = 2'd3
    } t_cfg_idx;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SH1,
        S_MXP,
        S_MXM,
        S_MXZ,
        S_SH2,
        S_OUT
    } t_state;

    // Operation broadcast to every cell.
    typedef enum logic [2:0] {
        OP_HOLD,
        OP_CLEAR,
        OP_SHIFT,
        OP_MIX_P,
        OP_MIX_M,
        OP_MIX_Z
    } t_cell_op;

    typedef struct packed {
        t_cell_op                  op;
        logic signed [DATA_W-1:0]  coef0;
        logic signed [DATA_W-1:0]  coef1;
        logic signed [DATA_W-1:0]  coef2;
    } t_cell_ctrl;

    // Saturate a wide sum to the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [ACC_W-1:0] x);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(36'sh0_7FFF_FFFF);
        lo = -ACC_W'(36'sh0_8000_0000);
        if (x > hi) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (x < lo) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[DATA_W-1:0];
        end
    endfunction

    // floor((x + 1) / 2), saturated.
    function automatic logic signed [DATA_W-1:0] half_sat(input logic signed [RND_W-1:0] x);
        logic signed [RND_W-1:0] s;
        s = (x + RND_W'(1)) >>> 1;
        half_sat = sat32(ACC_W'(s));
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/epg_cpmg_echo_train_core.sv */
`default_nettype none

// Channel     Direction  Signals                        Contents
// s_axis      in         tvalid/tready/tdata[31:0]      trans_decay
// m_axis      out        tvalid/tready/tdata[39:0]/tlast echo_amplitude, echo_index
// cfg         in         valid/ready/index[1:0]/data    register writes
//
// An item of N echoes runs one clear step, then per echo a shift, three
// mixing steps, a second shift and an output step that loads the result.
// Each cell of the row has three multiply lanes.
// Reset is synchronous and active low; it returns the sequencer to idle.
// A stalled output holds the sequencer in its output step; a new item is
// taken as soon as the last echo is loaded, even while it still waits.
module epg_cpmg_echo_train_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [31:0]  i_s_axis_tdata,   // [30:0] trans_decay
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [39:0]       o_m_axis_tdata,   // [31:0] echo_amplitude, [36:32] echo_index
    output logic              o_m_axis_tlast,
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [1:0]   i_cfg_index,
    input  wire logic [31:0]  i_cfg_data
);

    localparam int NC = epg_pkg::MAX_ECHOES;
    localparam int DW = epg_pkg::DATA_W;

    // Configuration registers.
    logic [epg_pkg::CNT_W-1:0] r_cfg_count;
    logic signed [DW-1:0]      r_cfg_cos, r_cfg_sin;
    logic [30:0]               r_cfg_long;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= epg_pkg::CNT_W'(NC);
            r_cfg_cos   <= -epg_pkg::Q_ONE;
            r_cfg_sin   <= '0;
            r_cfg_long  <= 31'h4000_0000;
        end else if (i_cfg_valid) begin
            case (epg_pkg::t_cfg_idx'(i_cfg_index))
                epg_pkg::CFG_ECHO_COUNT: r_cfg_count <= i_cfg_data[epg_pkg::CNT_W-1:0];
                epg_pkg::CFG_COS_ALPHA:  r_cfg_cos   <= i_cfg_data;
                epg_pkg::CFG_SIN_ALPHA:  r_cfg_sin   <= i_cfg_data;
                epg_pkg::CFG_LONG_DECAY: r_cfg_long  <= i_cfg_data[30:0];
                default: begin
                end
            endcase
        end
    end

    // Sequencer.
    epg_pkg::t_state r_state, n_state;
    logic [epg_pkg::CNT_W-1:0] r_n;
    logic [epg_pkg::IDX_W-1:0] r_echo;
    logic signed [DW-1:0] r_ca, r_cb, r_cc, r_cd, r_ce, r_cf, r_cg, r_e1, r_e2;
    logic                 r_ov;
    logic [DW-1:0]        r_amp;
    logic [epg_pkg::IDX_W-1:0] r_oidx;
    logic                 r_olast;
    logic                 in_xfer, out_free, is_last;
    logic [epg_pkg::CNT_W-1:0] cnt_clamped;
    logic signed [epg_pkg::RND_W-1:0] cos_w, sin_w;
    epg_pkg::t_cell_ctrl  ctrl;
    logic signed [DW-1:0] w_p [NC];
    logic signed [DW-1:0] w_m [NC];

    assign in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_ov || i_m_axis_tready;
    assign is_last  = ({1'b0, r_echo} + epg_pkg::CNT_W'(1)) == r_n;
    assign cos_w    = epg_pkg::RND_W'(r_cfg_cos);
    assign sin_w    = epg_pkg::RND_W'(r_cfg_sin);

    always_comb begin
        if (r_cfg_count == '0) begin
            cnt_clamped = epg_pkg::CNT_W'(1);
        end else if (r_cfg_count > epg_pkg::CNT_W'(NC)) begin
            cnt_clamped = epg_pkg::CNT_W'(NC);
        end else begin
            cnt_clamped = r_cfg_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= epg_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and cell operation.
    always_comb begin
        n_state         = r_state;
        o_s_axis_tready = 1'b0;
        ctrl.op         = epg_pkg::OP_HOLD;
        ctrl.coef0      = r_e2;
        ctrl.coef1      = r_e2;
        ctrl.coef2      = r_e1;
        case (r_state)
            epg_pkg::S_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    n_state = epg_pkg::S_CLEAR;
                end
            end
            epg_pkg::S_CLEAR: begin
                ctrl.op = epg_pkg::OP_CLEAR;
                n_state = epg_pkg::S_SH1;
            end
            epg_pkg::S_SH1: begin
                ctrl.op = epg_pkg::OP_SHIFT;
                n_state = epg_pkg::S_MXP;
            end
            epg_pkg::S_MXP: begin
                ctrl.op    = epg_pkg::OP_MIX_P;
                ctrl.coef0 = r_ca;
                ctrl.coef1 = r_cb;
                ctrl.coef2 = r_ce;
                n_state    = epg_pkg::S_MXM;
            end
            epg_pkg::S_MXM: begin
                ctrl.op    = epg_pkg::OP_MIX_M;
                ctrl.coef0 = r_cb;
                ctrl.coef1 = r_ca;
                ctrl.coef2 = r_cf;
                n_state    = epg_pkg::S_MXZ;
            end
            epg_pkg::S_MXZ: begin
                ctrl.op    = epg_pkg::OP_MIX_Z;
                ctrl.coef0 = r_cc;
                ctrl.coef1 = r_cd;
                ctrl.coef2 = r_cg;
                n_state    = epg_pkg::S_SH2;
            end
            epg_pkg::S_SH2: begin
                ctrl.op = epg_pkg::OP_SHIFT;
                n_state = epg_pkg::S_OUT;
            end
            epg_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = is_last ? epg_pkg::S_IDLE : epg_pkg::S_SH1;
                end
            end
            default: begin
                n_state = epg_pkg::S_IDLE;
            end
        endcase
    end

    // Coefficients, echo count and echo number per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_echo <= '0;
            r_n    <= epg_pkg::CNT_W'(1);
        end else if (in_xfer) begin
            r_echo <= '0;
            r_n    <= cnt_clamped;
            r_e2   <= DW'({1'b0, i_s_axis_tdata[30:0]});
            r_e1   <= DW'({1'b0, r_cfg_long});
            r_ca   <= epg_pkg::half_sat(epg_pkg::RND_W'(epg_pkg::Q_ONE) + cos_w);
            r_cb   <= epg_pkg::half_sat(epg_pkg::RND_W'(epg_pkg::Q_ONE) - cos_w);
            r_cc   <= r_cfg_sin;
            r_cd   <= epg_pkg::sat32(-epg_pkg::ACC_W'(r_cfg_sin));
            r_ce   <= epg_pkg::half_sat(-sin_w);
            r_cf   <= epg_pkg::half_sat(sin_w);
            r_cg   <= r_cfg_cos;
        end else if (r_state == epg_pkg::S_OUT && out_free && !is_last) begin
            r_echo <= r_echo + epg_pkg::IDX_W'(1);
        end
    end

    // Output register: loads F0 after the second shift of each echo.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == epg_pkg::S_OUT && out_free) begin
            r_ov <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == epg_pkg::S_OUT && out_free) begin
            r_amp   <= w_p[0];
            r_oidx  <= r_echo;
            r_olast <= is_last;
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {3'b000, r_oidx, r_amp};
    assign o_m_axis_tlast  = r_olast;

    // Row of cells; the highest live order sees zero from above.
    for (genvar k = 0; k < NC; k++) begin : g_cell
        logic signed [DW-1:0] m_src;
        logic signed [DW-1:0] p_src;
        if (k == NC - 1) begin : g_top
            assign m_src = '0;
        end else begin : g_mid
            assign m_src = (epg_pkg::CNT_W'(k + 1) >= r_n) ? '0 : w_m[k+1];
        end
        if (k == 0) begin : g_f0
            assign p_src = m_src;
        end else begin : g_ord
            assign p_src = w_p[k-1];
        end
        epg_cell u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (ctrl),
            .i_first  (k == 0),
            .i_p_prev (p_src),
            .i_m_next (m_src),
            .o_p      (w_p[k]),
            .o_m      (w_m[k])
        );
    end

    // Checks.
    a_seq_mix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == epg_pkg::S_SH1 |=> r_state == epg_pkg::S_MXP)
        else $error("mixing did not follow the first shift");

    a_echo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != epg_pkg::S_IDLE |-> {1'b0, r_echo} < r_n)
        else $error("echo number beyond train length");

    a_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state == epg_pkg::S_CLEAR)
        else $error("accepted item did not start with a clear");

endmodule

`default_nettype wire

/* hw/rtl/epg_cell.sv */
`default_nettype none

// One phase-graph order: holds F+k, F-k and Zk, with three multiply lanes.
module epg_cell (
    input  wire logic                               i_clk,
    input  wire epg_pkg::t_cell_ctrl                i_ctrl,
    input  wire logic                               i_first,
    input  wire logic signed [epg_pkg::DATA_W-1:0]  i_p_prev,
    input  wire logic signed [epg_pkg::DATA_W-1:0]  i_m_next,
    output logic signed [epg_pkg::DATA_W-1:0]       o_p,
    output logic signed [epg_pkg::DATA_W-1:0]       o_m
);

    logic signed [epg_pkg::DATA_W-1:0] r_p, r_m, r_z;
    logic signed [epg_pkg::ACC_W-1:0]  r_acc0, r_acc1, r_acc2;
    logic signed [epg_pkg::DATA_W-1:0] x0, x1, x2;
    logic signed [epg_pkg::PROD_W-1:0] prod0, prod1, prod2;
    logic signed [epg_pkg::RND_W-1:0]  rnd0, rnd1, rnd2;
    logic signed [epg_pkg::PROD_W-1:0] bias;

    assign bias = epg_pkg::PROD_W'(64'sd536870912);

    // Operand selection: shifts take the neighbors' F states and the local Z, mixing takes one local state.
    always_comb begin
        case (i_ctrl.op)
            epg_pkg::OP_SHIFT: begin
                x0 = i_p_prev;
                x1 = i_m_next;
                x2 = r_z;
            end
            epg_pkg::OP_MIX_M: begin
                x0 = r_m;
                x1 = r_m;
                x2 = r_m;
            end
            epg_pkg::OP_MIX_Z: begin
                x0 = r_z;
                x1 = r_z;
                x2 = r_z;
            end
            default: begin
                x0 = r_p;
                x1 = r_p;
                x2 = r_p;
            end
        endcase
    end

    // Products rounded half up to Q2.30.
    always_comb begin
        prod0 = x0 * i_ctrl.coef0;
        prod1 = x1 * i_ctrl.coef1;
        prod2 = x2 * i_ctrl.coef2;
        rnd0  = epg_pkg::RND_W'((prod0 + bias) >>> 30);
        rnd1  = epg_pkg::RND_W'((prod1 + bias) >>> 30);
        rnd2  = epg_pkg::RND_W'((prod2 + bias) >>> 30);
    end

    // State and accumulator update.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.op)
            epg_pkg::OP_CLEAR: begin
                r_p <= i_first ? epg_pkg::Q_ONE : '0;
                r_m <= '0;
                r_z <= '0;
            end
            epg_pkg::OP_SHIFT: begin
                r_p <= epg_pkg::sat32(epg_pkg::ACC_W'(rnd0));
                r_m <= epg_pkg::sat32(epg_pkg::ACC_W'(rnd1));
                r_z <= epg_pkg::sat32(epg_pkg::ACC_W'(rnd2));
            end
            epg_pkg::OP_MIX_P: begin
                r_acc0 <= epg_pkg::ACC_W'(rnd0);
                r_acc1 <= epg_pkg::ACC_W'(rnd1);
                r_acc2 <= epg_pkg::ACC_W'(rnd2);
            end
            epg_pkg::OP_MIX_M: begin
                r_acc0 <= r_acc0 + epg_pkg::ACC_W'(rnd0);
                r_acc1 <= r_acc1 + epg_pkg::ACC_W'(rnd1);
                r_acc2 <= r_acc2 + epg_pkg::ACC_W'(rnd2);
            end
            epg_pkg::OP_MIX_Z: begin
                // The F0 cell does not take part in mixing.
                if (!i_first) begin
                    r_p <= epg_pkg::sat32(r_acc0 + epg_pkg::ACC_W'(rnd0));
                    r_m <= epg_pkg::sat32(r_acc1 + epg_pkg::ACC_W'(rnd1));
                    r_z <= epg_pkg::sat32(r_acc2 + epg_pkg::ACC_W'(rnd2));
                end
            end
            default: begin
            end
        endcase
    end

    assign o_p = r_p;
    assign o_m = r_m;

endmodule

`default_nettype wire

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;

    localparam int ONE = 1 << 30;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [39:0] o_m_axis_tdata;
    logic        o_m_axis_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    epg_cpmg_echo_train_core DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tlast (o_m_axis_tlast),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    typedef struct {
        logic signed [31:0] amplitude;
        logic [4:0]         index;
        logic               last;
    } t_echo;

    // Shadow copy of the configuration registers.
    logic [5:0]         echo_cnt_reg;
    logic signed [31:0] cos_reg;
    logic signed [31:0] sin_reg;
    logic [30:0]        long_reg;

    t_echo  echo_queue[$];
    int     fail_count;
    int     stall_hold;
    bit     rx_busy_mode;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #200ms;
        $display("testbench: FAIL");
        $finish;
    end

    function automatic longint asr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -((-(v + 1)) >>> s) - 1;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qprod(longint a, longint b);
        return asr(a * b + (longint'(1) << 29), 30);
    endfunction

    // Run the phase-graph echo train for one decay factor and queue every echo.
    function automatic void predict_echo_train(logic [30:0] t2);
        longint fstate[65];
        longint zstate[32];
        longint e2, e1, ca, cb, cc, cd, ce, cf, cg, fp, fn, z;
        int n;
        t_echo r;
        e2 = longint'(t2);
        e1 = longint'(long_reg);
        ca = clip32(asr(longint'(ONE) + longint'(cos_reg) + 1, 1));
        cb = clip32(asr(longint'(ONE) - longint'(cos_reg) + 1, 1));
        cc = longint'(sin_reg);
        cd = clip32(-longint'(sin_reg));
        ce = clip32(asr(-longint'(sin_reg) + 1, 1));
        cf = clip32(asr(longint'(sin_reg) + 1, 1));
        cg = longint'(cos_reg);
        n = int'(echo_cnt_reg);
        if (n < 1) n = 1;
        if (n > epg_pkg::MAX_ECHOES) n = epg_pkg::MAX_ECHOES;
        foreach (fstate[i]) fstate[i] = 0;
        foreach (zstate[i]) zstate[i] = 0;
        fstate[n] = ONE;
        for (int ec = 0; ec < n; ec++) begin
            for (int h = 0; h < 2; h++) begin
                if (h == 1) begin
                    for (int k = 1; k < n; k++) begin
                        fp = fstate[n - k];
                        fn = fstate[n + k];
                        z  = zstate[n - k];
                        fstate[n - k] = clip32(qprod(ca, fp) + qprod(cb, fn) + qprod(cc, z));
                        fstate[n + k] = clip32(qprod(cb, fp) + qprod(ca, fn) + qprod(cd, z));
                        zstate[n - k] = clip32(qprod(ce, fp) + qprod(cf, fn) + qprod(cg, z));
                    end
                end
                for (int i = 0; i < 2 * n; i++) fstate[i] = clip32(qprod(fstate[i + 1], e2));
                for (int i = 0; i < n; i++) zstate[i] = clip32(qprod(zstate[i], e1));
            end
            r.amplitude = fstate[n][31:0];
            r.index = ec[4:0];
            r.last = (ec + 1 == n);
            echo_queue.push_back(r);
        end
    endfunction

    function automatic int random_gap();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // Receiver: random backpressure, plus a long hold-off when requested.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_busy_mode) begin
            i_m_axis_tready <= ($urandom_range(0, 3) != 0);
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // Compare each output transfer with the oldest expected echo.
    always @(posedge i_clk) begin
        t_echo exp_echo;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (echo_queue.size() == 0) begin
                $error("unexpected echo transfer, data %h", o_m_axis_tdata);
                fail_count++;
            end else begin
                exp_echo = echo_queue.pop_front();
                if (o_m_axis_tdata[31:0] !== exp_echo.amplitude) begin
                    $error("echo_amplitude expected %h actual %h",
                           exp_echo.amplitude, o_m_axis_tdata[31:0]);
                    fail_count++;
                end
                if (o_m_axis_tdata[36:32] !== exp_echo.index) begin
                    $error("echo_index expected %0d actual %0d",
                           exp_echo.index, o_m_axis_tdata[36:32]);
                    fail_count++;
                end
                if (o_m_axis_tlast !== exp_echo.last) begin
                    $error("last_echo expected %0b actual %0b", exp_echo.last, o_m_axis_tlast);
                    fail_count++;
                end
            end
        end
    end

    // Offer one item at a falling edge, after a random gap if asked; the valid drops after the transfer.
    task automatic send_decay(logic [30:0] t2, bit with_gap);
        int gap;
        gap = with_gap ? random_gap() : 0;
        repeat (gap + 1) @(negedge i_clk);
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {1'b0, t2};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        predict_echo_train(t2);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic write_reg(epg_pkg::t_cfg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            epg_pkg::CFG_ECHO_COUNT: echo_cnt_reg = value[5:0];
            epg_pkg::CFG_COS_ALPHA:  cos_reg = value;
            epg_pkg::CFG_SIN_ALPHA:  sin_reg = value;
            epg_pkg::CFG_LONG_DECAY: long_reg = value[30:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (echo_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_angle(logic [5:0] n, logic [31:0] c, logic [31:0] s, logic [30:0] t1);
        wait_drained();
        write_reg(epg_pkg::CFG_ECHO_COUNT, {26'd0, n});
        write_reg(epg_pkg::CFG_COS_ALPHA, c);
        write_reg(epg_pkg::CFG_SIN_ALPHA, s);
        write_reg(epg_pkg::CFG_LONG_DECAY, {1'b0, t1});
    endtask

    // Reset settings with extreme decays, including out-of-range ones.
    task automatic test_default_config();
        logic [30:0] decays[6] = '{31'd0, 31'd1, 31'(ONE), 31'(ONE / 2),
                                   31'h7FFF_FFFF, 31'h5555_5555};
        foreach (decays[i]) send_decay(decays[i], 1'b0);
    endtask

    // Echo counts of zero, one, the maximum and above the maximum.
    task automatic test_echo_counts();
        set_angle(6'd0, ONE / 2, 32'h376C_F5D1, 31'(ONE));
        send_decay(31'(ONE), 1'b0);
        set_angle(6'd1, -ONE, 0, 31'(ONE / 3));
        send_decay(31'h3000_0000, 1'b0);
        set_angle(6'd63, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_decay(31'h7FFF_FFFF, 1'b0);
        send_decay(31'h2AAA_AAAA, 1'b0);
        set_angle(6'd33, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
        send_decay(31'(ONE), 1'b0);
        send_decay(31'h0000_0001, 1'b0);
        set_angle(6'd32, ONE, ONE, 31'(ONE));
        send_decay(31'(ONE), 1'b0);
        set_angle(6'd5, 0, -ONE, 31'h3FFF_FFFF);
        send_decay(31'h3F00_0000, 1'b0);
    endtask

    // The receiver holds off while the sender keeps offering items.
    task automatic test_backpressure();
        set_angle(6'd4, -ONE, 0, 31'(ONE));
        stall_hold = 300;
        for (int i = 0; i < 6; i++) send_decay(31'($urandom_range(0, ONE)), 1'b0);
    endtask

    // Random decays over several random angle settings, with idling on both sides.
    task automatic test_random_trains();
        logic [5:0] n;
        for (int phase = 0; phase < 12; phase++) begin
            n = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 63))
                                            : 6'($urandom_range(1, 8));
            set_angle(n, $urandom(), $urandom(),
                      ($urandom_range(0, 1) != 0) ? 31'($urandom_range(0, ONE)) : 31'($urandom()));
            rx_busy_mode = (phase % 3 != 2);
            for (int i = 0; i < 25; i++) begin
                send_decay(($urandom_range(0, 3) == 0) ? 31'($urandom())
                                                       : 31'($urandom_range(0, ONE)),
                           rx_busy_mode);
            end
        end
    endtask

    initial begin
        fail_count = 0;
        stall_hold = 0;
        rx_busy_mode = 1'b1;
        echo_cnt_reg = 6'd32;
        cos_reg = -ONE;
        sin_reg = 0;
        long_reg = 31'(ONE);
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = epg_pkg::CFG_ECHO_COUNT;
        i_cfg_data = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_default_config();
        test_echo_counts();
        test_backpressure();
        test_random_trains();
        wait_drained();

        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
